// ===== hdl/bms_pkg.sv =====
// Shared types, constants and the falloff threshold table of the bump-map shader.
// Used by bms_window, bms_falloff, bump_map_shader and the testbench; depends on nothing else.
`default_nettype none

package bms_pkg;

  localparam int DEF_WIDTH  = 160;
  localparam int DEF_HEIGHT = 128;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;
  localparam int LIGHT_W    = 9;

  localparam logic [LIGHT_W-1:0] LIGHT_X_RESET = 9'd200;
  localparam logic [LIGHT_W-1:0] LIGHT_Y_RESET = 9'd192;

  // Falloff geometry: full brightness 255 at the centre 128, zero at radius 128.
  localparam int LEVEL_MAX    = 255;
  localparam int CENTER       = 128;
  localparam int RADIUS_LEVEL = LEVEL_MAX * CENTER;
  localparam int LEVEL_SQ     = LEVEL_MAX * LEVEL_MAX;

  localparam int SEARCH_BITS = 8;
  localparam int THRESH_W    = 15;
  localparam int DIST_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X,
    REG_LIGHT_Y
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] height;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic [7:0] lit_pixel;
    logic       frame_end;
  } lit_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       frame_end;
  } coord_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] light_x;
    logic [LIGHT_W-1:0] light_y;
  } light_t;

  typedef logic [255:0][THRESH_W-1:0] thresh_t;

  // Level v is reached when the squared distance is at most
  // floor((32640 - 128*v)^2 / 65025). The thresholds fall as v rises.
  function automatic thresh_t build_thresh();
    thresh_t t;
    longint  m;
    for (int v = 0; v < 256; v++) begin
      m    = longint'(RADIUS_LEVEL) - longint'(CENTER) * longint'(v);
      t[v] = THRESH_W'((m * m) / LEVEL_SQ);
    end
    return t;
  endfunction

  localparam thresh_t THRESH = build_thresh();

endpackage

`default_nettype wire

// ===== hdl/bms_window.sv =====
// Raster window of the bump-map shader: delay line, stream position, gradients.
// Produces clamped table coordinates per centre pixel; uses bms_pkg.
`default_nettype none

module bms_window #(
  parameter int WIDTH  = bms_pkg::DEF_WIDTH,
  parameter int HEIGHT = bms_pkg::DEF_HEIGHT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pix_valid,
  output logic                 pix_stall,
  input  wire bms_pkg::pix_t   pix,
  input  wire bms_pkg::light_t light,
  output logic                 win_valid,
  input  wire logic            win_stall,
  output bms_pkg::coord_t      win_coord
);

  localparam int FRAME_LEN = (HEIGHT + 2) * WIDTH;
  localparam int LINE_LEN  = 2 * WIDTH;
  localparam int POS_W     = $clog2(FRAME_LEN + 1);
  localparam int COL_W     = $clog2(WIDTH);
  localparam int ACC_W     = $clog2(HEIGHT * WIDTH);
  localparam int RT_W      = (ACC_W > 8) ? ACC_W - 8 : 1;
  localparam int MAG_A     = (COL_W > RT_W) ? COL_W : RT_W;
  localparam int MAG_W     = (MAG_A > 10) ? MAG_A : 10;
  localparam int SUM_W     = MAG_W + 2;

  logic [7:0]       line [LINE_LEN];
  logic [POS_W-1:0] pos;
  logic [COL_W-1:0] col;
  logic [ACC_W-1:0] rowacc;

  logic             accept;
  logic [POS_W-1:0] p;
  logic [POS_W-1:0] pos_next;
  logic [COL_W-1:0] col_cur;
  logic [COL_W-1:0] col_next;
  logic [ACC_W-1:0] rowacc_cur;
  logic [ACC_W-1:0] rowacc_next;
  logic [RT_W-1:0]  rowterm;
  logic             has_res;
  logic             frame_end;
  logic signed [SUM_W-1:0] nx_sum;
  logic signed [SUM_W-1:0] ny_sum;
  logic [7:0]       nx;
  logic [7:0]       ny;

  assign pix_stall = win_valid && win_stall;
  assign accept    = pix_valid && !pix_stall;

  always_comb begin
    p          = pix.frame_start ? '0 : pos;
    col_cur    = pix.frame_start ? '0 : col;
    rowacc_cur = pix.frame_start ? '0 : rowacc;
    pos_next   = (p < POS_W'(FRAME_LEN)) ? p + POS_W'(1) : p;
    has_res    = (p >= POS_W'(2 * WIDTH)) && (p < POS_W'(FRAME_LEN));
    frame_end  = (p == POS_W'(FRAME_LEN - 1));

    col_next    = col_cur;
    rowacc_next = rowacc_cur;
    if (has_res) begin
      if (col_cur == COL_W'(WIDTH - 1)) begin
        col_next = '0;
        if (rowacc_cur == ACC_W'((HEIGHT - 1) * WIDTH)) begin
          rowacc_next = '0;
        end else begin
          rowacc_next = rowacc_cur + ACC_W'(WIDTH);
        end
      end else begin
        col_next = col_cur + COL_W'(1);
      end
    end
  end

  assign rowterm = RT_W'(rowacc_cur >> 8);

  // Taps are taken as they stand after this byte shifts in: the newest byte is
  // the lower neighbour, the oldest is the upper one.
  always_comb begin
    nx_sum = $signed(SUM_W'(line[WIDTH - 2])) - $signed(SUM_W'(line[WIDTH]))
           + $signed(SUM_W'(light.light_x)) - $signed(SUM_W'(col_cur));
    ny_sum = $signed(SUM_W'(pix.height)) - $signed(SUM_W'(line[LINE_LEN - 1]))
           + $signed(SUM_W'(light.light_y)) - $signed(SUM_W'(rowterm));
    nx = (nx_sum < 0 || nx_sum > $signed(SUM_W'(255))) ? 8'd0 : nx_sum[7:0];
    ny = (ny_sum < 0 || ny_sum > $signed(SUM_W'(255))) ? 8'd0 : ny_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      col       <= '0;
      rowacc    <= '0;
      win_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos    <= pos_next;
        col    <= col_next;
        rowacc <= rowacc_next;
      end
      if (!pix_stall) begin
        win_valid <= accept && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line[0] <= pix.height;
      for (int i = 1; i < LINE_LEN; i++) begin
        line[i] <= line[i - 1];
      end
      win_coord.x         <= nx;
      win_coord.y         <= ny;
      win_coord.frame_end <= frame_end;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && pix.frame_start |=> pos == POS_W'(1))
    else $error("stream position did not restart on frame start");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && has_res |=> win_valid)
    else $error("centre pixel transfer did not load the coordinate register");

endmodule

`default_nettype wire

// ===== hdl/bms_falloff.sv =====
// Radial falloff pipeline: squared distance, then one level bit per stage
// found against the threshold table; the last stage is the result register.
// Uses bms_pkg.
`default_nettype none

module bms_falloff (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire bms_pkg::coord_t coord,
  output logic                 lit_valid,
  input  wire logic            lit_stall,
  output bms_pkg::lit_t        lit
);

  localparam int NST = bms_pkg::SEARCH_BITS + 1;
  localparam int DW  = bms_pkg::DIST_W;

  logic [NST-1:0] vld;
  logic [NST-1:0] adv;
  logic [DW-1:0]  d2q [NST];
  logic [7:0]     vq  [NST];
  logic [NST-1:0] feq;

  logic [7:0]     ax;
  logic [7:0]     ay;
  logic [DW-1:0]  d2_in;
  logic [7:0]     vn  [NST];

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[NST-1] = !vld[NST-1] || !lit_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i + 1];
    end
  end

  assign in_stall = !adv[0];

  // The offsets are widened before squaring; an offset of 128 squares to 16384.
  always_comb begin
    ax    = (coord.x >= 8'(bms_pkg::CENTER)) ? coord.x - 8'(bms_pkg::CENTER)
                                             : 8'(bms_pkg::CENTER) - coord.x;
    ay    = (coord.y >= 8'(bms_pkg::CENTER)) ? coord.y - 8'(bms_pkg::CENTER)
                                             : 8'(bms_pkg::CENTER) - coord.y;
    d2_in = DW'(ax) * DW'(ax) + DW'(ay) * DW'(ay);
  end

  // Stage i tries the next lower level bit and keeps it when the threshold of
  // the candidate level still covers the distance. Beyond the rim no candidate
  // passes and the level stays zero.
  always_comb begin
    logic [7:0] cand;
    vn[0] = '0;
    for (int i = 1; i < NST; i++) begin
      cand  = vq[i - 1] | (8'd1 << (bms_pkg::SEARCH_BITS - i));
      vn[i] = (DW'(bms_pkg::THRESH[cand]) >= d2q[i - 1]) ? cand : vq[i - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      d2q[0] <= d2_in;
      vq[0]  <= vn[0];
      feq[0] <= coord.frame_end;
    end
    for (int i = 1; i < NST; i++) begin
      if (adv[i] && vld[i - 1]) begin
        d2q[i] <= d2q[i - 1];
        vq[i]  <= vn[i];
        feq[i] <= feq[i - 1];
      end
    end
  end

  assign lit_valid     = vld[NST-1];
  assign lit.lit_pixel = vq[NST-1];
  assign lit.frame_end = feq[NST-1];

  a_first_hold: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !adv[0] |=> vld[0] && $stable(d2q[0]))
    else $error("distance stage lost or changed a held item");

  a_first_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && adv[0] |=> vld[0])
    else $error("coordinate transfer did not reach the distance stage");

endmodule

`default_nettype wire

// ===== hdl/bump_map_shader.sv =====
// Top level of the bump-map shader: light registers and the two pipeline parts.
// Instantiates bms_window and bms_falloff; uses bms_pkg.
//
//   Channel  Signals                          Carries
//   pix      pix_valid, pix_stall, pix        height byte and frame_start, one per transfer
//   lit      lit_valid, lit_stall, lit        lit_pixel and frame_end, one per centre pixel
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data   light_x (0), light_y (1)
//
// One pixel per clock is taken in steady flow while lit_stall stays low; a result passes
// through one coordinate register, a distance stage and eight level-search stages.
// The first 2*WIDTH bytes of a frame and bytes after it give no result.
// Reset (synchronous) clears the stream position, the pipeline valids and the
// light registers; the delay line is not cleared and needs no clearing pass.
// lit_stall holds the pipeline from the back; pix_stall rises only once every
// stage holds an item. cfg_ready is always high.
`default_nettype none

module bump_map_shader #(
  parameter int WIDTH  = bms_pkg::DEF_WIDTH,
  parameter int HEIGHT = bms_pkg::DEF_HEIGHT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pix_valid,
  output logic                                 pix_stall,
  input  wire bms_pkg::pix_t                   pix,
  output logic                                 lit_valid,
  input  wire logic                            lit_stall,
  output bms_pkg::lit_t                        lit,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bms_pkg::light_t light;
  logic            win_valid;
  logic            win_stall;
  bms_pkg::coord_t win_coord;

  assign cfg_ready = 1'b1;

  // Indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      light.light_x <= bms_pkg::LIGHT_X_RESET;
      light.light_y <= bms_pkg::LIGHT_Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bms_pkg::REG_LIGHT_X: light.light_x <= cfg_data;
        bms_pkg::REG_LIGHT_Y: light.light_y <= cfg_data;
        default: ;
      endcase
    end
  end

  bms_window #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .light     (light),
    .win_valid (win_valid),
    .win_stall (win_stall),
    .win_coord (win_coord)
  );

  bms_falloff u_falloff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_stall  (win_stall),
    .coord     (win_coord),
    .lit_valid (lit_valid),
    .lit_stall (lit_stall),
    .lit       (lit)
  );

endmodule

`default_nettype wire

// ===== test/bump_map_shader_test.sv =====
// Self-checking testbench for bump_map_shader: streams height-map frames through the
// pixel channel, predicts every lit pixel in-line and compares it with the block's output.
// Depends on bms_pkg and the bump_map_shader RTL only.

module bump_map_shader_test;

  localparam int WIDTH     = bms_pkg::DEF_WIDTH;
  localparam int HEIGHT    = bms_pkg::DEF_HEIGHT;
  localparam int PRIME     = 2 * WIDTH;
  localparam int FRAME_LEN = (HEIGHT + 2) * WIDTH;
  localparam int HIST_LEN  = 1 << $clog2(2 * WIDTH + 1);

  // Falloff geometry: level 255 at the centre, zero at radius 128.
  localparam longint MID      = 128;
  localparam longint RIM      = 255 * 128;
  localparam longint SCALE_SQ = 255 * 255;
  localparam longint ROOT_MAX = 65535;

  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT  = 4000;
  localparam int REPORT_CAP   = 100;

  typedef enum int {RELIEF_NOISE, RELIEF_SMOOTH, RELIEF_BINARY} relief_e;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  bms_pkg::pix_t pix;
  logic lit_valid;
  logic lit_stall;
  bms_pkg::lit_t lit;
  logic cfg_valid;
  logic cfg_ready;
  logic [bms_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bms_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor state.
  logic [bms_pkg::LIGHT_W-1:0] model_light_x = bms_pkg::LIGHT_X_RESET;
  logic [bms_pkg::LIGHT_W-1:0] model_light_y = bms_pkg::LIGHT_Y_RESET;
  int unsigned stream_pos = 0;
  int unsigned hist_head = 0;
  logic [7:0] height_hist [HIST_LEN];
  bms_pkg::lit_t expected_lit [$];

  int unsigned error_count = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  bump_map_shader #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) uut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix),
    .lit_valid(lit_valid),
    .lit_stall(lit_stall),
    .lit(lit),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Exact floor(255 * (1 - r / 128)) with the square root rounded up, zero past the rim.
  function automatic logic [7:0] falloff_level(input logic [7:0] x, input logic [7:0] y);
    longint dx, dy, t, lo, hi, mid, s;
    dx = longint'(x) - MID;
    dy = longint'(y) - MID;
    t = SCALE_SQ * (dx * dx + dy * dy);
    lo = 0;
    hi = ROOT_MAX;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= t) lo = mid;
      else hi = mid - 1;
    end
    s = lo;
    if (s * s < t) s++;
    if (s > RIM) return 8'd0;
    return 8'((RIM - s) / 128);
  endfunction

  function automatic logic [7:0] past_height(input int unsigned lag);
    return height_hist[(hist_head - lag) % HIST_LEN];
  endfunction

  // Advances the stream model by one byte and queues the lit pixel it produces, if any.
  function automatic void predict_lit(input bms_pkg::pix_t p);
    int unsigned pos, k, col, row;
    int nx, ny;
    bms_pkg::lit_t r;
    if (p.frame_start) stream_pos = 0;
    pos = stream_pos;
    if (stream_pos < FRAME_LEN) stream_pos++;
    hist_head++;
    height_hist[hist_head % HIST_LEN] = p.height;
    if (pos < PRIME || pos >= FRAME_LEN) return;
    k = pos - PRIME;
    col = k % WIDTH;
    row = k / WIDTH;
    nx = int'(past_height(WIDTH - 1)) - int'(past_height(WIDTH + 1))
         + int'(model_light_x) - int'(col);
    ny = int'(past_height(0)) - int'(past_height(2 * WIDTH))
         + int'(model_light_y) - int'((row * WIDTH) >> 8);
    if (nx < 0 || nx > 255) nx = 0;
    if (ny < 0 || ny > 255) ny = 0;
    r.lit_pixel = falloff_level(nx[7:0], ny[7:0]);
    r.frame_end = (pos == FRAME_LEN - 1);
    expected_lit.push_back(r);
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one; always back to back when calm.
  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [bms_pkg::LIGHT_W-1:0] pick_light();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return bms_pkg::LIGHT_W'($urandom_range(0, (1 << bms_pkg::LIGHT_W) - 1));
  endfunction

  task automatic send_pixel(input logic [7:0] h, input logic fs);
    int unsigned gap;
    gap = pick_idle(tx_calm);
    if ($urandom_range(0, 999) == 0) tx_calm = !tx_calm;
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= '{height: h, frame_start: fs};
    do @(posedge clk); while (pix_stall);
    predict_lit('{height: h, frame_start: fs});
  endtask

  // With restart set the first byte carries frame_start, otherwise the stream
  // carries on; stray restarts appear at about 1 in stray bytes.
  task automatic send_frame(input int unsigned count, input relief_e relief,
                            input int unsigned stray, input bit restart);
    int level;
    logic [7:0] h;
    logic fs;
    level = $urandom_range(0, 255);
    for (int unsigned i = 0; i < count; i++) begin
      case (relief)
        RELIEF_SMOOTH: begin
          level += int'($urandom_range(0, 8)) - 4;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          h = level[7:0];
        end
        RELIEF_BINARY: begin
          h = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default: begin
          h = 8'($urandom_range(0, 255));
        end
      endcase
      fs = (restart && i == 0) || (stray != 0 && $urandom_range(1, stray) == 1);
      send_pixel(h, fs);
    end
  endtask

  // Waits until every expected pixel has arrived and the pipeline has emptied.
  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (expected_lit.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [bms_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bms_pkg::CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bms_pkg::REG_LIGHT_X) model_light_x = value;
    else if (idx == bms_pkg::REG_LIGHT_Y) model_light_y = value;
  endtask

  task automatic test_reset_lights();
    send_frame(PRIME + 16, RELIEF_SMOOTH, 0, 1'b1);
  endtask

  // Full-scale gradients against the extreme light positions drive both clamps.
  task automatic test_gradient_clamps();
    logic [bms_pkg::LIGHT_W-1:0] corners [4];
    corners = '{'0, '1, '0, '1};
    for (int i = 0; i < 4; i++) begin
      write_register(bms_pkg::REG_LIGHT_X, corners[i]);
      write_register(bms_pkg::REG_LIGHT_Y, corners[(i + 1) % 4]);
      send_frame(20, RELIEF_BINARY, 0, 1'b0);
    end
  endtask

  task automatic test_ignored_index();
    for (int idx = int'(bms_pkg::REG_LIGHT_Y) + 1; idx < (1 << bms_pkg::CFG_IDX_W); idx++)
      write_register(bms_pkg::CFG_IDX_W'(idx),
                     bms_pkg::CFG_DATA_W'($urandom_range(0, 511)));
    send_frame(16, RELIEF_NOISE, 0, 1'b0);
  endtask

  task automatic test_restart_mid_frame();
    send_frame(30, RELIEF_NOISE, 0, 1'b0);
    send_frame(1, RELIEF_NOISE, 0, 1'b1);
    send_frame(2, RELIEF_NOISE, 0, 1'b1);
    send_frame(PRIME + 10, RELIEF_NOISE, 0, 1'b1);
  endtask

  task automatic test_random_frames();
    relief_e relief;
    for (int round = 0; round < 10; round++) begin
      if ($urandom_range(0, 2) != 0) write_register(bms_pkg::REG_LIGHT_X, pick_light());
      if ($urandom_range(0, 2) != 0) write_register(bms_pkg::REG_LIGHT_Y, pick_light());
      relief = relief_e'($urandom_range(0, 2));
      send_frame(8 + $urandom_range(0, 16), relief, 0, 1'b0);
    end
  endtask

  // Result side: checks every transfer, then picks the stall for the next cycle.
  initial begin
    int unsigned stall_left;
    bms_pkg::lit_t want;
    stall_left = 0;
    lit_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && lit_valid && !lit_stall) begin
        if (expected_lit.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $error("lit transfer with nothing expected: lit_pixel %0d, frame_end %0d",
                   lit.lit_pixel, lit.frame_end);
        end else begin
          want = expected_lit.pop_front();
          if (lit.lit_pixel !== want.lit_pixel) begin
            error_count++;
            if (error_count <= REPORT_CAP)
              $error("lit_pixel: expected %0d, actual %0d", want.lit_pixel, lit.lit_pixel);
          end
          if (lit.frame_end !== want.frame_end) begin
            error_count++;
            if (error_count <= REPORT_CAP)
              $error("frame_end: expected %0d, actual %0d", want.frame_end, lit.frame_end);
          end
        end
      end
      if ($urandom_range(0, 999) == 0) rx_calm = !rx_calm;
      if (stall_left == 0) stall_left = pick_idle(rx_calm);
      lit_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pix_valid && !pix_stall) || (lit_valid && !lit_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("bump_map_shader_test failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    pix_valid <= 1'b0;
    pix <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_lights();
    test_gradient_clamps();
    test_ignored_index();
    test_restart_mid_frame();
    test_random_frames();

    wait_idle();
    if (error_count == 0)
      $display("bump_map_shader_test passed");
    else
      $display("bump_map_shader_test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bms_pkg.sv
hdl/bms_window.sv
hdl/bms_falloff.sv
hdl/bump_map_shader.sv
test/bump_map_shader_test.sv
